/* rtl/dldr_pkg.sv */
// Shared types, constants and the power-of-ten table for the long-division row block.
package dldr_pkg;

	localparam int DATA_W     = 32;
	localparam int NUM_DIGITS = 10;  // decimal digits of the largest DATA_W-bit quotient
	localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
	localparam int STEP_W     = $clog2(DATA_W);

	localparam logic [1:0] KIND_QUOTIENT  = 2'd0;
	localparam logic [1:0] KIND_DIVIDEND  = 2'd1;
	localparam logic [1:0] KIND_PRODUCT   = 2'd2;
	localparam logic [1:0] KIND_REMAINDER = 2'd3;

	typedef struct packed {
		logic       load;      // take a new operand pair
		logic       div_step;  // one restoring-division iteration
		logic       cnt_step;  // advance the digit-count position
		logic       dig_step;  // one subtract of the current power of ten
		logic       mul;       // register digit*pw*divisor
		logic       emit;      // load the output register
		logic [1:0] kind;
		logic       last;
		logic       err;
	} dldr_cmd_t;

	typedef struct packed {
		logic dvs_zero;  // divisor on the input bus is zero
		logic cnt_done;  // digit count settled
		logic dig_done;  // current digit extracted
		logic k_zero;    // working on the units digit
		logic out_free;  // output register can take a word
	} dldr_stat_t;

	function automatic logic [DATA_W-1:0] pow10(input logic [DIG_W-1:0] idx);
		logic [DATA_W-1:0] p;
		case (idx)
			4'd0: p = DATA_W'(64'd1);
			4'd1: p = DATA_W'(64'd10);
			4'd2: p = DATA_W'(64'd100);
			4'd3: p = DATA_W'(64'd1000);
			4'd4: p = DATA_W'(64'd10000);
			4'd5: p = DATA_W'(64'd100000);
			4'd6: p = DATA_W'(64'd1000000);
			4'd7: p = DATA_W'(64'd10000000);
			4'd8: p = DATA_W'(64'd100000000);
			4'd9: p = DATA_W'(64'd1000000000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

/* rtl/dldr_dp.sv */
// Datapath: restoring divider, decimal digit extraction, product/remainder and output register.
module dldr_dp import dldr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dldr_cmd_t           cmd,
	output dldr_stat_t          stat,
	input  logic [DATA_W-1:0]   dividend,
	input  logic [DATA_W-1:0]   divisor,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_kind,
	output logic [DATA_W-1:0]   out_value,
	output logic                out_last,
	output logic                out_err
);

	logic [DATA_W-1:0]   dvs_q;    // divisor
	logic [DATA_W-1:0]   pr_q;     // division partial remainder
	logic [DATA_W-1:0]   dq_q;     // dividend -> quotient -> leftover quotient digits
	logic [DATA_W-1:0]   rem_q;    // running remainder, starts at dividend
	logic [DATA_W-1:0]   acc_q;    // digit * 10^k
	logic [DATA_W-1:0]   prod_q;   // partial product
	logic [DIG_W-1:0]    k_q;      // decimal position
	logic                out_valid_q;
	logic [1:0]          out_kind_q;
	logic [DATA_W-1:0]   out_value_q;
	logic                out_last_q;
	logic                out_err_q;

	logic [DATA_W:0]     trial;
	logic [DATA_W:0]     trial_sub;
	logic [DATA_W-1:0]   pw;
	logic [DATA_W-1:0]   pw_next;
	logic [2*DATA_W-1:0] prod_full;
	logic [DATA_W-1:0]   row_value;

	assign trial     = {pr_q, dq_q[DATA_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign pw        = pow10(k_q);
	assign pw_next   = pow10(k_q + DIG_W'(1));
	assign prod_full = acc_q * dvs_q;

	always_comb begin
		unique case (cmd.kind)
			KIND_QUOTIENT:  row_value = dq_q;
			KIND_DIVIDEND:  row_value = rem_q;
			KIND_PRODUCT:   row_value = prod_q;
			KIND_REMAINDER: row_value = rem_q;
			default:        row_value = '0;
		endcase
		if (cmd.err)
			row_value = '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvs_q <= divisor;
			pr_q  <= '0;
			dq_q  <= dividend;
			rem_q <= dividend;
			acc_q <= '0;
			k_q   <= '0;
		end
		if (cmd.div_step) begin
			if (!trial_sub[DATA_W]) begin
				pr_q <= trial_sub[DATA_W-1:0];
				dq_q <= {dq_q[DATA_W-2:0], 1'b1};
			end else begin
				pr_q <= trial[DATA_W-1:0];
				dq_q <= {dq_q[DATA_W-2:0], 1'b0};
			end
		end
		if (cmd.cnt_step)
			k_q <= k_q + DIG_W'(1);
		if (cmd.dig_step && dq_q >= pw) begin
			dq_q  <= dq_q - pw;
			acc_q <= acc_q + pw;
		end
		if (cmd.mul)
			prod_q <= prod_full[DATA_W-1:0];
		if (cmd.emit && cmd.kind == KIND_PRODUCT)
			rem_q <= rem_q - prod_q;
		if (cmd.emit && cmd.kind == KIND_REMAINDER && !cmd.last) begin
			k_q   <= k_q - DIG_W'(1);
			acc_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q  <= cmd.kind;
			out_value_q <= row_value;
			out_last_q  <= cmd.last;
			out_err_q   <= cmd.err;
		end
	end

	assign stat.dvs_zero = (divisor == '0);
	assign stat.cnt_done = (k_q == DIG_W'(NUM_DIGITS - 1)) || (dq_q < pw_next);
	assign stat.dig_done = (dq_q < pw);
	assign stat.k_zero   = (k_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

endmodule

/* rtl/dldr_ctrl.sv */
// Controller: sequences division, digit count and row emission for one operand pair.
module dldr_ctrl import dldr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dldr_stat_t stat,
	output dldr_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_CNT  = 4'd2;
	localparam logic [3:0] ST_EMQ  = 4'd3;
	localparam logic [3:0] ST_EMD  = 4'd4;
	localparam logic [3:0] ST_DIG  = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_EMP  = 4'd7;
	localparam logic [3:0] ST_EMR  = 4'd8;
	localparam logic [3:0] ST_ERR  = 4'd9;

	logic [3:0]        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = stat.dvs_zero ? ST_ERR : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DATA_W - 1))
					state_nxt = ST_CNT;
			end
			ST_CNT: begin
				if (stat.cnt_done)
					state_nxt = ST_EMQ;
				else
					cmd.cnt_step = 1'b1;
			end
			ST_EMQ: begin
				cmd.kind = KIND_QUOTIENT;
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_EMD;
				end
			end
			ST_EMD: begin
				cmd.kind = KIND_DIVIDEND;
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_DIG;
				end
			end
			ST_DIG: begin
				if (stat.dig_done)
					state_nxt = ST_MUL;
				else
					cmd.dig_step = 1'b1;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_EMP;
			end
			ST_EMP: begin
				cmd.kind = KIND_PRODUCT;
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_EMR;
				end
			end
			ST_EMR: begin
				cmd.kind = KIND_REMAINDER;
				cmd.last = stat.k_zero;
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = stat.k_zero ? ST_IDLE : ST_DIG;
				end
			end
			ST_ERR: begin
				cmd.kind = KIND_QUOTIENT;
				cmd.last = 1'b1;
				cmd.err  = 1'b1;
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

/* rtl/decimal_long_division_rows.sv */
// Top level of the decimal long-division row generator.
//
// Takes one word holding an unsigned dividend and divisor and sends out the
// rows of a schoolbook decimal long division: the quotient, the dividend, then
// for each decimal digit of the quotient (most significant first) the partial
// product digit*10^k*divisor followed by the running remainder. A zero
// quotient has one digit, so a normal operation gives 2 + 2*d words with d
// from 1 to 10; tlast marks the final remainder. A zero divisor gives a single
// word, kind quotient, value 0, with the error flag and tlast set. One
// operation is in flight at a time. An operation accepts the input word, runs the
// restoring divider (one quotient bit per cycle), counts the quotient digits,
// sends the quotient and dividend words, then per digit repeats the power-of-ten
// subtraction, forms the product in the 32x32 multiplier and sends two words.
// The last word sits in the output register, so the next input word is taken
// while it still waits for the sink.
module decimal_long_division_rows import dldr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [2*DATA_W-1:0] s_axis_tdata,   // [31:0] dividend, [63:32] divisor
	// output stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] row_value
	output logic [2:0]          m_axis_tuser,   // [1:0] row_kind, [2] divide_error
	output logic                m_axis_tlast    // last_row
);

	dldr_cmd_t  cmd;
	dldr_stat_t stat;
	logic [1:0] out_kind;
	logic       out_err;

	dldr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dldr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.dividend  (s_axis_tdata[DATA_W-1:0]),
		.divisor   (s_axis_tdata[2*DATA_W-1:DATA_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (out_kind),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_err   (out_err)
	);

	assign m_axis_tuser = {out_err, out_kind};

`ifndef SYNTHESIS
	// error word is always the only word of its operation
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_err |-> m_axis_tlast && out_kind == KIND_QUOTIENT
			&& m_axis_tdata == '0)
		else $error("error word without tlast or with data");

	// a normal operation always ends on a remainder word
	a_last_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && !out_err |-> out_kind == KIND_REMAINDER)
		else $error("tlast on a non-remainder word");

	// a new input is taken only when no word is being loaded
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !cmd.emit)
		else $error("input accepted during row emission");

	// a remainder word always directly follows its partial product
	a_rem_after_prod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.kind == KIND_REMAINDER |-> $past(cmd.emit)
			|| $past(cmd.kind) == KIND_REMAINDER)
		else $error("remainder word out of sequence");
`endif

endmodule
